@@ src/radiotap_frame_classifier_core_defines.svh @@
// Assertion macros for the classifier RTL.
// Each macro expects clk_i and the active-low reset rst_ni in scope.
`ifndef RADIOTAP_FRAME_CLASSIFIER_CORE_DEFINES_SVH
`define RADIOTAP_FRAME_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RTFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rtfc_pkg.sv @@
`default_nettype none

package rtfc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65536;
  // Position counter saturates at MAX_PACKET_BYTES, so it must hold that value.
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  // Compare width: room for a header length plus the beacon offset.
  localparam int unsigned CMP_W = ((POS_W > 16) ? POS_W : 16) + 1;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HDR_W    = 16;
  localparam int unsigned FC_W     = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned BSSID_W  = 48;
  localparam int unsigned CLASS_W  = 3;

  localparam int unsigned POS_LEAD         = 0;
  localparam int unsigned POS_LEN_LO       = 2;
  localparam int unsigned POS_LEN_HI       = 3;
  localparam int unsigned POS_BODY         = 8;
  localparam int unsigned MIN_PACKET_BYTES = 10;
  localparam int unsigned MIN_HDR_BYTES    = 8;
  localparam int unsigned FC_BYTES         = 2;
  localparam int unsigned BSSID_OFFSET     = 16;
  localparam int unsigned BEACON_MIN_BYTES = 22;

  localparam logic [3:0] SUBTYPE_BEACON = 4'd8;
  localparam logic [1:0] PROTO_VERSION  = 2'd0;

  typedef enum logic [CLASS_W-1:0] {
    CLS_INVALID       = 3'd0,
    CLS_BAD_VERSION   = 3'd1,
    CLS_MGMT          = 3'd2,
    CLS_BEACON_OTHER  = 3'd3,
    CLS_BEACON_TARGET = 3'd4,
    CLS_CTRL          = 3'd5,
    CLS_DATA          = 3'd6,
    CLS_RESERVED      = 3'd7
  } class_e;

  typedef enum logic [1:0] {
    FT_MGMT     = 2'd0,
    FT_CTRL     = 2'd1,
    FT_DATA     = 2'd2,
    FT_RESERVED = 2'd3
  } ftype_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              looped;
  } rtfc_beat_t;

  typedef struct packed {
    class_e            class_code;
    logic [HDR_W-1:0]  radiotap_length;
    logic [FC_W-1:0]   frame_control;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  management_count;
    logic [CNT_W-1:0]  control_count;
    logic [CNT_W-1:0]  data_frame_count;
    logic [CNT_W-1:0]  beacon_count;
    logic [CNT_W-1:0]  target_beacon_count;
  } rtfc_result_t;

endpackage

`default_nettype wire

@@ src/rtfc_in_stage.sv @@
`default_nettype none

module rtfc_in_stage
  import rtfc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic              looped_back_i,
  input  wire logic              take_i,
  output logic                   beat_valid_o,
  output rtfc_beat_t             beat_o
);

  logic       valid_q, valid_d;
  rtfc_beat_t beat_q;
  logic       accept;

  // Hold the byte while the parser cannot take it.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.data   <= data_byte_i;
      beat_q.last   <= last_byte_i;
      beat_q.looped <= looped_back_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

@@ src/rtfc_parser.sv @@
`default_nettype none

module rtfc_parser
  import rtfc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [BSSID_W-1:0] cfg_data_i,
  input  wire logic               beat_valid_i,
  input  wire rtfc_beat_t         beat_i,
  input  wire logic               out_free_i,
  output logic                    take_o,
  output logic                    res_valid_o,
  output rtfc_result_t            res_o
);

  `include "radiotap_frame_classifier_core_defines.svh"

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

  logic [BSSID_W-1:0] target_q;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [HDR_W-1:0]   hdr_q, hdr_d;
  logic [FC_W-1:0]    fc_q, fc_d;
  logic               lead_q, lead_d;
  logic               match_q, match_d;
  logic               skip_q, skip_d;

  logic [CNT_W-1:0] cnt_total_q, cnt_total_d;
  logic [CNT_W-1:0] cnt_mgmt_q, cnt_mgmt_d;
  logic [CNT_W-1:0] cnt_ctrl_q, cnt_ctrl_d;
  logic [CNT_W-1:0] cnt_data_q, cnt_data_d;
  logic [CNT_W-1:0] cnt_bcn_q, cnt_bcn_d;
  logic [CNT_W-1:0] cnt_tgt_q, cnt_tgt_d;

  logic [CMP_W-1:0]  pos_e, hdr_e, bssid_lo, bssid_off;
  logic [2:0]        bssid_idx;
  logic [BYTE_W-1:0] want_byte;
  logic              in_window;

  logic [CMP_W-1:0] len_e, hdr_n;
  logic             bad_hdr, long_beacon, pkt_end;
  ftype_e           ftype;
  class_e           cls;
  rtfc_result_t     res;

  assign take_o  = beat_valid_i && (!beat_i.last || out_free_i);
  assign pkt_end = take_o && beat_i.last;

  // BSSID window relative to the radiotap header.
  assign pos_e     = CMP_W'(pos_q);
  assign hdr_e     = CMP_W'(hdr_q);
  assign bssid_lo  = hdr_e + CMP_W'(BSSID_OFFSET);
  assign in_window = (pos_e >= bssid_lo) && (pos_e < hdr_e + CMP_W'(BEACON_MIN_BYTES));
  assign bssid_off = pos_e - bssid_lo;
  assign bssid_idx = bssid_off[2:0];

  always_comb begin
    case (bssid_idx)
      3'd0:    want_byte = target_q[47:40];
      3'd1:    want_byte = target_q[39:32];
      3'd2:    want_byte = target_q[31:24];
      3'd3:    want_byte = target_q[23:16];
      3'd4:    want_byte = target_q[15:8];
      3'd5:    want_byte = target_q[7:0];
      default: want_byte = '0;
    endcase
  end

  // Per-byte capture; bytes past the size limit leave the state alone.
  always_comb begin
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    fc_d    = fc_q;
    lead_d  = lead_q;
    match_d = match_q;
    skip_d  = skip_q;
    if (pos_q < MAX_POS) begin
      pos_d = pos_q + POS_W'(1);
      if (pos_q == POS_W'(POS_LEAD)) begin
        lead_d = (beat_i.data != '0);
        skip_d = beat_i.looped;
      end else if (pos_q == POS_W'(POS_LEN_LO)) begin
        hdr_d[7:0] = beat_i.data;
      end else if (pos_q == POS_W'(POS_LEN_HI)) begin
        hdr_d[15:8] = beat_i.data;
      end else if (pos_q >= POS_W'(POS_BODY)) begin
        if (pos_e == hdr_e) begin
          fc_d[7:0] = beat_i.data;
        end else if (pos_e == hdr_e + CMP_W'(1)) begin
          fc_d[15:8] = beat_i.data;
        end
        if (in_window && (want_byte != beat_i.data)) begin
          match_d = 1'b0;
        end
      end
    end
  end

  // Classification at the final byte, on the freshly updated state.
  assign len_e       = CMP_W'(pos_d);
  assign hdr_n       = CMP_W'(hdr_d);
  assign bad_hdr     = (len_e < CMP_W'(MIN_PACKET_BYTES)) || lead_d
                    || (hdr_n < CMP_W'(MIN_HDR_BYTES))
                    || (len_e < hdr_n + CMP_W'(FC_BYTES));
  assign long_beacon = (len_e >= hdr_n + CMP_W'(BEACON_MIN_BYTES));
  assign ftype       = ftype_e'(fc_d[3:2]);

  always_comb begin
    cls = CLS_INVALID;
    if (bad_hdr) begin
      cls = CLS_INVALID;
    end else if (fc_d[1:0] != PROTO_VERSION) begin
      cls = CLS_BAD_VERSION;
    end else begin
      case (ftype)
        FT_MGMT: begin
          if ((fc_d[7:4] == SUBTYPE_BEACON) && long_beacon) begin
            cls = match_d ? CLS_BEACON_TARGET : CLS_BEACON_OTHER;
          end else begin
            cls = CLS_MGMT;
          end
        end
        FT_CTRL: cls = CLS_CTRL;
        FT_DATA: cls = CLS_DATA;
        default: cls = CLS_RESERVED;
      endcase
    end
  end

  always_comb begin
    cnt_total_d = cnt_total_q;
    cnt_mgmt_d  = cnt_mgmt_q;
    cnt_ctrl_d  = cnt_ctrl_q;
    cnt_data_d  = cnt_data_q;
    cnt_bcn_d   = cnt_bcn_q;
    cnt_tgt_d   = cnt_tgt_q;
    if (pkt_end && !skip_d) begin
      cnt_total_d = cnt_total_q + CNT_W'(1);
      if ((cls == CLS_MGMT) || (cls == CLS_BEACON_OTHER) || (cls == CLS_BEACON_TARGET)) begin
        cnt_mgmt_d = cnt_mgmt_q + CNT_W'(1);
      end
      if ((cls == CLS_BEACON_OTHER) || (cls == CLS_BEACON_TARGET)) begin
        cnt_bcn_d = cnt_bcn_q + CNT_W'(1);
      end
      if (cls == CLS_BEACON_TARGET) begin
        cnt_tgt_d = cnt_tgt_q + CNT_W'(1);
      end
      if (cls == CLS_CTRL) begin
        cnt_ctrl_d = cnt_ctrl_q + CNT_W'(1);
      end
      if (cls == CLS_DATA) begin
        cnt_data_d = cnt_data_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    res.class_code          = cls;
    res.radiotap_length     = hdr_d;
    res.frame_control       = bad_hdr ? '0 : fc_d;
    res.total_count         = cnt_total_d;
    res.management_count    = cnt_mgmt_d;
    res.control_count       = cnt_ctrl_d;
    res.data_frame_count    = cnt_data_d;
    res.beacon_count        = cnt_bcn_d;
    res.target_beacon_count = cnt_tgt_d;
  end

  assign res_valid_o = pkt_end && !skip_d;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      pos_q       <= '0;
      hdr_q       <= '0;
      fc_q        <= '0;
      lead_q      <= 1'b0;
      match_q     <= 1'b1;
      skip_q      <= 1'b0;
      cnt_total_q <= '0;
      cnt_mgmt_q  <= '0;
      cnt_ctrl_q  <= '0;
      cnt_data_q  <= '0;
      cnt_bcn_q   <= '0;
      cnt_tgt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      if (take_o) begin
        if (beat_i.last) begin
          // Drop per-packet state at the end of every packet.
          pos_q   <= '0;
          hdr_q   <= '0;
          fc_q    <= '0;
          lead_q  <= 1'b0;
          match_q <= 1'b1;
          skip_q  <= 1'b0;
        end else begin
          pos_q   <= pos_d;
          hdr_q   <= hdr_d;
          fc_q    <= fc_d;
          lead_q  <= lead_d;
          match_q <= match_d;
          skip_q  <= skip_d;
        end
      end
      cnt_total_q <= cnt_total_d;
      cnt_mgmt_q  <= cnt_mgmt_d;
      cnt_ctrl_q  <= cnt_ctrl_d;
      cnt_data_q  <= cnt_data_d;
      cnt_bcn_q   <= cnt_bcn_d;
      cnt_tgt_q   <= cnt_tgt_d;
    end
  end

  `RTFC_ASSERT_NOW(a_pos_bounded, 1'b1, pos_q <= MAX_POS, "byte position beyond limit")
  `RTFC_ASSERT_NEXT(a_pos_cleared, pkt_end, pos_q == '0, "position not cleared at packet end")
  `RTFC_ASSERT_NEXT(a_total_step, res_valid_o,
    cnt_total_q == $past(cnt_total_q) + CNT_W'(1), "total count did not advance by one")
  `RTFC_ASSERT_NEXT(a_cnt_hold, !take_o, $stable(cnt_total_q) && $stable(cnt_tgt_q),
    "counters moved without a transfer")

endmodule

`default_nettype wire

@@ src/rtfc_out_stage.sv @@
`default_nettype none

module rtfc_out_stage
  import rtfc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         res_valid_i,
  input  wire rtfc_result_t res_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output rtfc_result_t      res_o
);

  logic         valid_q, valid_d;
  rtfc_result_t res_q;

  // Free when empty or when the held result leaves this cycle.
  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_free_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ src/radiotap_frame_classifier_core.sv @@
// Radiotap frame classifier: monitor-mode packets enter one byte per transfer on
// the input channel (in_valid_i / in_stall_o), with last_byte_i marking the final
// byte and looped_back_i sampled on the first byte of each packet.
// Each packet that is not looped back yields one result transfer on the output
// channel (out_valid_o / out_stall_i): class code, radiotap length, frame control
// word and six wrapping 32-bit counters as they stand after the packet.
// Looped-back packets are dropped silently; bytes past 65536 are ignored.
// Throughput: one byte per cycle, sustained while the receiver does not stall, with no gaps between packets.
// Path: a byte is registered in the input register on acceptance and parsed
// from there; at the final byte the parser classifies the packet and the result
// is registered in the output register, which drives out_valid_o. Only the input
// and output registers lie on this path; nothing iterates.
// Stall: while a result waits in the output register, non-final bytes keep
// flowing; only a final byte waits for the register to free, and while it
// waits the input stalls as well.
// Reset (rst_ni low, asynchronous) empties both registers, clears all counters
// and the per-packet state, and sets target BSSID to zero. Write the BSSID via
// cfg_we_i / cfg_data_i (first octet in bits 47..40) only while idle.
`default_nettype none

module radiotap_frame_classifier_core
  import rtfc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [BSSID_W-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [BYTE_W-1:0]  data_byte_i,
  input  wire logic               last_byte_i,
  input  wire logic               looped_back_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CLASS_W-1:0]      class_code_o,
  output logic [HDR_W-1:0]        radiotap_length_o,
  output logic [FC_W-1:0]         frame_control_o,
  output logic [CNT_W-1:0]        total_count_o,
  output logic [CNT_W-1:0]        management_count_o,
  output logic [CNT_W-1:0]        control_count_o,
  output logic [CNT_W-1:0]        data_frame_count_o,
  output logic [CNT_W-1:0]        beacon_count_o,
  output logic [CNT_W-1:0]        target_beacon_count_o
);

  logic         beat_valid;
  rtfc_beat_t   beat;
  logic         take;
  logic         out_free;
  logic         res_valid;
  rtfc_result_t res;
  rtfc_result_t res_out;

  // Input register: one byte deep, refilled in the cycle it drains.
  rtfc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .looped_back_i (looped_back_i),
    .take_i        (take),
    .beat_valid_o  (beat_valid),
    .beat_o        (beat)
  );

  // Header capture, classification and counters.
  rtfc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .out_free_i   (out_free),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register: parts the parser from a stalling receiver.
  rtfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign class_code_o          = res_out.class_code;
  assign radiotap_length_o     = res_out.radiotap_length;
  assign frame_control_o       = res_out.frame_control;
  assign total_count_o         = res_out.total_count;
  assign management_count_o    = res_out.management_count;
  assign control_count_o       = res_out.control_count;
  assign data_frame_count_o    = res_out.data_frame_count;
  assign beacon_count_o        = res_out.beacon_count;
  assign target_beacon_count_o = res_out.target_beacon_count;

endmodule

`default_nettype wire
